FILE: rtl/core/deb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package deb_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int MAX_IRQ     = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int DATA_W      = 32;
   localparam int OFS_W       = 12;
   localparam int IRQ_W       = 5;
   localparam int IRQ_CNT_W   = 6;
   localparam int NAME_W      = 8;
   localparam int STATUS_W    = 3;
   localparam int CSR_IDX_W   = 1;
   localparam int NEXT_IRQ_W  = 6;
   localparam int IRQ_SUM_W   = NEXT_IRQ_W + 1;

   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   localparam logic [OFS_W-1:0] OFS_OP        = 12'h000;
   localparam logic [OFS_W-1:0] OFS_GET_NAME  = 12'h004;
   localparam logic [OFS_W-1:0] OFS_NAME_LEN  = 12'h008;
   localparam logic [OFS_W-1:0] OFS_ID        = 12'h00c;
   localparam logic [OFS_W-1:0] OFS_BASE      = 12'h010;
   localparam logic [OFS_W-1:0] OFS_SIZE      = 12'h014;
   localparam logic [OFS_W-1:0] OFS_IRQ       = 12'h018;
   localparam logic [OFS_W-1:0] OFS_IRQ_COUNT = 12'h01c;

   localparam logic [DATA_W-1:0] ANSWER_ADD  = 32'd8;
   localparam logic [DATA_W-1:0] ANSWER_DONE = 32'd0;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_IRQ   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_OFS  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_OP   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_FREE_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_FREE_IRQ  = 1'b1;

   localparam logic [DATA_W-1:0]     RESET_FREE_BASE = 32'd0;
   localparam logic [NEXT_IRQ_W-1:0] RESET_FREE_IRQ  = 6'd1;

   typedef struct packed {
      logic [DATA_W-1:0]    ident;
      logic [DATA_W-1:0]    window_base;
      logic [DATA_W-1:0]    window_size;
      logic [IRQ_W-1:0]     first_irq;
      logic [IRQ_CNT_W-1:0] irq_lines;
      logic [NAME_W-1:0]    name_bytes;
   } entry_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] index;
   } scan_type;

endpackage

`default_nettype wire

FILE: rtl/core/deb_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface deb_req_if import deb_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              req_type;
   logic [OFS_W-1:0]        reg_offset;
   logic [DATA_W-1:0]       write_value;
   logic signed [DATA_W-1:0] dev_id;
   logic [DATA_W-1:0]       dev_base;
   logic [DATA_W-1:0]       dev_size;
   logic [IRQ_W-1:0]        dev_irq;
   logic [IRQ_CNT_W-1:0]    dev_irq_count;
   logic [NAME_W-1:0]       name_length;

   modport source (
      output valid, req_type, reg_offset, write_value, dev_id, dev_base, dev_size,
             dev_irq, dev_irq_count, name_length,
      input  ready
   );
   modport sink (
      input  valid, req_type, reg_offset, write_value, dev_id, dev_base, dev_size,
             dev_irq, dev_irq_count, name_length,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/core/deb_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface deb_rsp_if import deb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   read_data;
   logic                bus_irq_level;
   logic [DATA_W-1:0]   assigned_base;
   logic [IRQ_W-1:0]    assigned_irq;
   logic [STATUS_W-1:0] status;
   logic                copy_request;
   logic [DATA_W-1:0]   copy_address;
   logic [NAME_W-1:0]   copy_length;
   logic [IDX_W-1:0]    copy_entry;

   modport source (
      output valid, read_data, bus_irq_level, assigned_base, assigned_irq, status,
             copy_request, copy_address, copy_length, copy_entry,
      input  ready
   );
   modport sink (
      input  valid, read_data, bus_irq_level, assigned_base, assigned_irq, status,
             copy_request, copy_address, copy_length, copy_entry,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/core/deb_csr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface deb_csr_if import deb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/deb_table_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module deb_table_ram import deb_pkg::*; (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire entry_type        wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output entry_type             rd_data_ff
);

   entry_type mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/deb_scan.sv
`timescale 1ns / 1ps
`default_nettype none

// Finds the lowest entry at or above start_idx that exists and is not yet reported.
module deb_scan import deb_pkg::*; (
   input  wire logic [TABLE_DEPTH-1:0] reported,
   input  wire logic [CNT_W-1:0]       start_idx,
   input  wire logic [CNT_W-1:0]       total,
   output scan_type                    result
);

   logic [TABLE_DEPTH-1:0] cand;

   always_comb begin
      for (int j = 0; j < TABLE_DEPTH; j++) begin
         cand[j] = !reported[j] && (CNT_W'(j) < total) && (CNT_W'(j) >= start_idx);
      end
   end

   always_comb begin
      result.found = |cand;
      result.index = '0;
      for (int j = TABLE_DEPTH - 1; j >= 0; j--) begin
         if (cand[j]) begin
            result.index = IDX_W'(j);
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/device_enumeration_bus_top.sv
`timescale 1ns / 1ps
`default_nettype none

// A request is accepted only in the idle state, where the table memory read of the
// current entry is made; the response is registered in the execute state, and no new
// request is taken until it completes. A response waiting on the output holds the request
// in its execute state until the output register frees up.
// Reset (synchronous): table empty, reported marks and cursor cleared, bus IRQ low,
// next free base 0 and next free IRQ 1. Table contents are undefined until written.
module device_enumeration_bus_top import deb_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   deb_req_if.sink   req_ch,
   deb_rsp_if.source rsp_ch,
   deb_csr_if.sink   csr_ch
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;

   // Latched request.
   logic [1:0]           type_ff;
   logic [OFS_W-1:0]     ofs_ff;
   logic [DATA_W-1:0]    wval_ff;
   logic [DATA_W-1:0]    id_ff;
   logic [DATA_W-1:0]    base_ff;
   logic [DATA_W-1:0]    size_ff;
   logic [IRQ_W-1:0]     irq_ff;
   logic [IRQ_CNT_W-1:0] cnt_ff;
   logic [NAME_W-1:0]    name_ff;

   // Control state.
   logic [TABLE_DEPTH-1:0] reported_ff, reported_in;
   logic [CNT_W-1:0]       total_ff, total_in;
   logic [IDX_W-1:0]       cursor_ff, cursor_in;
   logic                   present_ff, present_in;
   logic [DATA_W-1:0]      free_base_ff, free_base_in;
   logic [NEXT_IRQ_W-1:0]  free_irq_ff, free_irq_in;
   logic                   irq_line_ff, irq_line_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   r_data_ff, r_data_in;
   logic [DATA_W-1:0]   r_base_ff, r_base_in;
   logic [IRQ_W-1:0]    r_irq_ff, r_irq_in;
   logic [STATUS_W-1:0] r_status_ff, r_status_in;
   logic                r_copy_ff, r_copy_in;
   logic [DATA_W-1:0]   r_caddr_ff, r_caddr_in;
   logic [NAME_W-1:0]   r_clen_ff, r_clen_in;
   logic [IDX_W-1:0]    r_centry_ff, r_centry_in;

   logic           req_acc;
   logic           done;
   logic           wr_en;
   entry_type      wr_data;
   entry_type      rd_data;
   scan_type       scan;
   logic [CNT_W-1:0] scan_start;

   logic                 auto_irq;
   logic [IRQ_SUM_W-1:0] irq_sum;
   logic [DATA_W-1:0]    add_base;
   logic [IRQ_W-1:0]     add_irq;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign done         = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   deb_table_ram u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (total_ff[IDX_W-1:0]),
      .wr_data    (wr_data),
      .rd_en      (req_acc),
      .rd_addr    (cursor_ff),
      .rd_data_ff (rd_data)
   );

   assign scan_start = present_ff ? (CNT_W'(cursor_ff) + CNT_W'(1)) : '0;

   deb_scan u_scan (
      .reported  (reported_ff),
      .start_idx (scan_start),
      .total     (total_ff),
      .result    (scan)
   );

   assign auto_irq = (irq_ff == '0) && (cnt_ff != '0);
   assign irq_sum  = IRQ_SUM_W'(free_irq_ff) + IRQ_SUM_W'(cnt_ff);
   assign add_base = (base_ff == '0) ? free_base_ff : base_ff;
   assign add_irq  = auto_irq ? free_irq_ff[IRQ_W-1:0] : irq_ff;

   always_comb begin
      wr_data.ident       = id_ff;
      wr_data.window_base = add_base;
      wr_data.window_size = size_ff;
      wr_data.first_irq   = add_irq;
      wr_data.irq_lines   = cnt_ff;
      wr_data.name_bytes  = name_ff;
   end

   always_comb begin
      state_in     = state_ff;
      reported_in  = reported_ff;
      total_in     = total_ff;
      cursor_in    = cursor_ff;
      present_in   = present_ff;
      free_base_in = free_base_ff;
      free_irq_in  = free_irq_ff;
      irq_line_in  = irq_line_ff;
      wr_en        = 1'b0;

      r_data_in   = '0;
      r_base_in   = '0;
      r_irq_in    = '0;
      r_status_in = STATUS_OK;
      r_copy_in   = 1'b0;
      r_caddr_in  = '0;
      r_clen_in   = '0;
      r_centry_in = '0;

      if (state_ff == S_IDLE) begin
         if (req_acc) begin
            state_in = S_EXEC;
         end
      end else begin
         case (type_ff)
            REQ_ADD: begin
               if (total_ff == CNT_W'(TABLE_DEPTH)) begin
                  r_status_in = STATUS_FULL;
               end else if (auto_irq && (irq_sum >= IRQ_SUM_W'(MAX_IRQ))) begin
                  r_status_in = STATUS_NO_IRQ;
               end else begin
                  wr_en = 1'b1;
                  reported_in[total_ff[IDX_W-1:0]] = 1'b0;
                  total_in = total_ff + CNT_W'(1);
                  if (base_ff == '0) begin
                     free_base_in = free_base_ff + size_ff;
                  end
                  if (auto_irq) begin
                     free_irq_in = irq_sum[NEXT_IRQ_W-1:0];
                  end
                  r_base_in = add_base;
                  r_irq_in  = add_irq;
               end
            end
            REQ_READ: begin
               if (ofs_ff == OFS_OP) begin
                  if (present_ff) begin
                     reported_in[cursor_ff] = 1'b1;
                  end
                  if (scan.found) begin
                     cursor_in  = scan.index;
                     present_in = 1'b1;
                     r_data_in  = ANSWER_ADD;
                  end else begin
                     cursor_in   = '0;
                     present_in  = 1'b0;
                     irq_line_in = 1'b0;
                     r_data_in   = ANSWER_DONE;
                  end
               end else if (ofs_ff == OFS_NAME_LEN) begin
                  r_data_in = present_ff ? DATA_W'(rd_data.name_bytes) : '0;
               end else if (ofs_ff == OFS_ID) begin
                  r_data_in = present_ff ? rd_data.ident : '0;
               end else if (ofs_ff == OFS_BASE) begin
                  r_data_in = present_ff ? rd_data.window_base : '0;
               end else if (ofs_ff == OFS_SIZE) begin
                  r_data_in = present_ff ? rd_data.window_size : '0;
               end else if (ofs_ff == OFS_IRQ) begin
                  r_data_in = present_ff ? DATA_W'(rd_data.first_irq) : '0;
               end else if (ofs_ff == OFS_IRQ_COUNT) begin
                  r_data_in = present_ff ? DATA_W'(rd_data.irq_lines) : '0;
               end else begin
                  r_status_in = STATUS_BAD_OFS;
               end
            end
            REQ_WRITE: begin
               if (ofs_ff == OFS_OP) begin
                  if (wval_ff == '0) begin
                     reported_in = '0;
                     cursor_in   = '0;
                     present_in  = 1'b0;
                     irq_line_in = (total_ff != '0);
                  end else begin
                     r_status_in = STATUS_BAD_OP;
                  end
               end else if (ofs_ff == OFS_GET_NAME) begin
                  if (present_ff) begin
                     r_copy_in   = 1'b1;
                     r_caddr_in  = wval_ff;
                     r_clen_in   = rd_data.name_bytes;
                     r_centry_in = cursor_ff;
                  end
               end else begin
                  r_status_in = STATUS_BAD_OFS;
               end
            end
            default: begin
            end
         endcase

         if (done) begin
            state_in = S_IDLE;
         end else begin
            // Hold everything until the output register frees up.
            reported_in  = reported_ff;
            total_in     = total_ff;
            cursor_in    = cursor_ff;
            present_in   = present_ff;
            free_base_in = free_base_ff;
            free_irq_in  = free_irq_ff;
            irq_line_in  = irq_line_ff;
            wr_en        = 1'b0;
         end
      end

      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_FIRST_FREE_BASE: free_base_in = csr_ch.data;
            CSR_FIRST_FREE_IRQ:  free_irq_in  = NEXT_IRQ_W'(csr_ch.data[IRQ_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         reported_ff  <= '0;
         total_ff     <= '0;
         cursor_ff    <= '0;
         present_ff   <= 1'b0;
         free_base_ff <= RESET_FREE_BASE;
         free_irq_ff  <= RESET_FREE_IRQ;
         irq_line_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reported_ff  <= reported_in;
         total_ff     <= total_in;
         cursor_ff    <= cursor_in;
         present_ff   <= present_in;
         free_base_ff <= free_base_in;
         free_irq_ff  <= free_irq_in;
         irq_line_ff  <= irq_line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         type_ff <= req_ch.req_type;
         ofs_ff  <= req_ch.reg_offset;
         wval_ff <= req_ch.write_value;
         id_ff   <= $unsigned(req_ch.dev_id);
         base_ff <= req_ch.dev_base;
         size_ff <= req_ch.dev_size;
         irq_ff  <= req_ch.dev_irq;
         cnt_ff  <= req_ch.dev_irq_count;
         name_ff <= req_ch.name_length;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         r_data_ff   <= r_data_in;
         r_base_ff   <= r_base_in;
         r_irq_ff    <= r_irq_in;
         r_status_ff <= r_status_in;
         r_copy_ff   <= r_copy_in;
         r_caddr_ff  <= r_caddr_in;
         r_clen_ff   <= r_clen_in;
         r_centry_ff <= r_centry_in;
      end
   end

   // The bus IRQ level reported is the one after the request completes.
   logic irq_level_ff;

   always_ff @(posedge clock) begin
      if (done) begin
         irq_level_ff <= irq_line_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.read_data     = r_data_ff;
   assign rsp_ch.bus_irq_level = irq_level_ff;
   assign rsp_ch.assigned_base = r_base_ff;
   assign rsp_ch.assigned_irq  = r_irq_ff;
   assign rsp_ch.status        = r_status_ff;
   assign rsp_ch.copy_request  = r_copy_ff;
   assign rsp_ch.copy_address  = r_caddr_ff;
   assign rsp_ch.copy_length   = r_clen_ff;
   assign rsp_ch.copy_entry    = r_centry_ff;

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import deb_pkg::*;

   localparam logic [1:0] REQ_UNUSED    = 2'd3;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         PHASE_ITEMS   = 205;
   localparam logic [OFS_W-1:0] FIELD_OFS [6] = '{OFS_NAME_LEN, OFS_ID, OFS_BASE, OFS_SIZE,
                                                  OFS_IRQ, OFS_IRQ_COUNT};

   typedef struct packed {
      logic [1:0]               kind;
      logic [OFS_W-1:0]         ofs;
      logic [DATA_W-1:0]        wval;
      logic signed [DATA_W-1:0] id;
      logic [DATA_W-1:0]        base;
      logic [DATA_W-1:0]        size;
      logic [IRQ_W-1:0]         irq;
      logic [IRQ_CNT_W-1:0]     cnt;
      logic [NAME_W-1:0]        name;
   } bus_req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic                irq_level;
      logic [DATA_W-1:0]   assigned_base;
      logic [IRQ_W-1:0]    assigned_irq;
      logic [STATUS_W-1:0] status;
      logic                copy_req;
      logic [DATA_W-1:0]   copy_addr;
      logic [NAME_W-1:0]   copy_len;
      logic [IDX_W-1:0]    copy_entry;
   } bus_answer_type;

   logic clock = 1'b0;
   logic reset;

   deb_req_if req_if ();
   deb_rsp_if rsp_if ();
   deb_csr_if csr_if ();

   device_enumeration_bus_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #1 clock = ~clock;

   // Shadow of the device table and the walk state.
   entry_type              dev_table [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] reported;
   int                     dev_count;
   logic [IDX_W-1:0]       walk_idx;
   logic                   walk_valid;
   logic [DATA_W-1:0]      free_base;
   int                     free_irq;
   logic                   bus_irq;

   bus_req_type    pending_reqs [$];
   bus_answer_type expected_answers [$];
   bus_req_type    cur_req;
   bit             req_taken;
   bit             hold_rsp;
   int             requests_taken;
   int             error_count;
   int             queued;

   int stored_count, full_count, no_irq_count, walks_finished, copy_count, bad_count;

   wire calm = (requests_taken >= 600) && (requests_taken < 800);

   function automatic logic [DATA_W-1:0] advance_walk();
      int i;
      if (walk_valid) begin
         reported[walk_idx] = 1'b1;
         i = walk_idx + 1;
      end else begin
         i = 0;
      end
      while (i < dev_count && reported[i]) i++;
      if (i < dev_count) begin
         walk_idx   = i[IDX_W-1:0];
         walk_valid = 1'b1;
         return ANSWER_ADD;
      end
      walk_idx   = '0;
      walk_valid = 1'b0;
      bus_irq    = 1'b0;
      walks_finished++;
      return ANSWER_DONE;
   endfunction

   function automatic bus_answer_type predict_answer(input bus_req_type rq);
      bus_answer_type a;
      logic [DATA_W-1:0] base;
      logic [DATA_W-1:0] nbase;
      logic [IRQ_W-1:0]  irq;
      int                nirq;
      entry_type         e;
      a = '0;
      case (rq.kind)
         REQ_ADD: begin
            if (dev_count >= TABLE_DEPTH) begin
               a.status = STATUS_FULL;
               full_count++;
            end else begin
               base  = rq.base;
               irq   = rq.irq;
               nbase = free_base;
               nirq  = free_irq;
               if (base == '0) begin
                  base  = nbase;
                  nbase = nbase + rq.size;
               end
               if (irq == '0 && rq.cnt != '0) begin
                  irq  = nirq[IRQ_W-1:0];
                  nirq = nirq + rq.cnt;
               end
               // A refused add leaves the device count and the free pointers where they were.
               if (nirq >= MAX_IRQ) begin
                  a.status = STATUS_NO_IRQ;
                  no_irq_count++;
               end else begin
                  e.ident       = rq.id;
                  e.window_base = base;
                  e.window_size = rq.size;
                  e.first_irq   = irq;
                  e.irq_lines   = rq.cnt;
                  e.name_bytes  = rq.name;
                  dev_table[dev_count] = e;
                  reported[dev_count]  = 1'b0;
                  dev_count++;
                  free_base       = nbase;
                  free_irq        = nirq;
                  a.assigned_base = base;
                  a.assigned_irq  = irq;
                  stored_count++;
               end
            end
         end
         REQ_READ: begin
            if (rq.ofs == OFS_OP) begin
               a.read_data = advance_walk();
            end else if (rq.ofs >= OFS_NAME_LEN && rq.ofs <= OFS_IRQ_COUNT &&
                         rq.ofs[1:0] == 2'b00) begin
               if (walk_valid) begin
                  e = dev_table[walk_idx];
                  case (rq.ofs)
                     OFS_NAME_LEN: a.read_data = DATA_W'(e.name_bytes);
                     OFS_ID:       a.read_data = e.ident;
                     OFS_BASE:     a.read_data = e.window_base;
                     OFS_SIZE:     a.read_data = e.window_size;
                     OFS_IRQ:      a.read_data = DATA_W'(e.first_irq);
                     default:      a.read_data = DATA_W'(e.irq_lines);
                  endcase
               end
            end else begin
               a.status = STATUS_BAD_OFS;
               bad_count++;
            end
         end
         REQ_WRITE: begin
            if (rq.ofs == OFS_OP) begin
               if (rq.wval == '0) begin
                  reported   = '0;
                  walk_idx   = '0;
                  walk_valid = 1'b0;
                  bus_irq    = (dev_count > 0);
               end else begin
                  a.status = STATUS_BAD_OP;
                  bad_count++;
               end
            end else if (rq.ofs == OFS_GET_NAME) begin
               if (walk_valid) begin
                  a.copy_req   = 1'b1;
                  a.copy_addr  = rq.wval;
                  a.copy_len   = dev_table[walk_idx].name_bytes;
                  a.copy_entry = walk_idx;
                  copy_count++;
               end
            end else begin
               a.status = STATUS_BAD_OFS;
               bad_count++;
            end
         end
         default: ;
      endcase
      a.irq_level = bus_irq;
      return a;
   endfunction

   function automatic bus_req_type random_req();
      bus_req_type r;
      r.kind = 2'($urandom_range(3));
      r.ofs  = OFS_W'($urandom_range(4095));
      r.wval = $urandom;
      r.id   = $urandom;
      r.base = $urandom;
      r.size = $urandom;
      r.irq  = IRQ_W'($urandom_range(31));
      r.cnt  = IRQ_CNT_W'($urandom_range(32));
      r.name = NAME_W'($urandom_range(255));
      return r;
   endfunction

   task automatic push_access(input logic [1:0] kind, input logic [OFS_W-1:0] ofs,
                              input logic [DATA_W-1:0] value);
      bus_req_type r;
      r      = random_req();
      r.kind = kind;
      r.ofs  = ofs;
      r.wval = value;
      pending_reqs.push_back(r);
      queued++;
   endtask

   task automatic push_add(input logic [DATA_W-1:0] id, input logic [DATA_W-1:0] base,
                           input logic [DATA_W-1:0] size, input logic [IRQ_W-1:0] irq,
                           input logic [IRQ_CNT_W-1:0] cnt, input logic [NAME_W-1:0] name);
      bus_req_type r;
      r      = random_req();
      r.kind = REQ_ADD;
      r.id   = id;
      r.base = base;
      r.size = size;
      r.irq  = irq;
      r.cnt  = cnt;
      r.name = name;
      pending_reqs.push_back(r);
      queued++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_if.index <= idx;
      csr_if.data  <= value;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      if (idx == CSR_FIRST_FREE_BASE)
         free_base = value;
      else
         free_irq = int'(value[IRQ_W-1:0]);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Waits until every request has been answered and the block has gone quiet.
   task automatic settle_block();
      while (pending_reqs.size() != 0 || req_if.valid || expected_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic compare_field(input string field, input logic [DATA_W-1:0] exp_val,
                                input logic [DATA_W-1:0] act_val);
      if (exp_val !== act_val) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_val, act_val);
      end
   endtask

   // Request driver
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         expected_answers.push_back(predict_answer(cur_req));
         req_taken = 1'b1;
         requests_taken++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         req_taken = 1'b0;
         if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
            cur_req = pending_reqs.pop_front();
            req_if.req_type      <= cur_req.kind;
            req_if.reg_offset    <= cur_req.ofs;
            req_if.write_value   <= cur_req.wval;
            req_if.dev_id        <= cur_req.id;
            req_if.dev_base      <= cur_req.base;
            req_if.dev_size      <= cur_req.size;
            req_if.dev_irq       <= cur_req.irq;
            req_if.dev_irq_count <= cur_req.cnt;
            req_if.name_length   <= cur_req.name;
            req_if.valid         <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response side
   always @(negedge clock) begin
      if (reset || hold_rsp)
         rsp_if.ready <= 1'b0;
      else if (calm)
         rsp_if.ready <= 1'b1;
      else
         rsp_if.ready <= ($urandom_range(99) >= 10);
   end

   always @(posedge clock) begin : answer_monitor
      bus_answer_type exp_a;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_answers.size() == 0) begin
            error_count++;
            $display("%0t: response with no request outstanding, expected none, got status %0d",
                     $time, rsp_if.status);
         end else begin
            exp_a = expected_answers.pop_front();
            compare_field("read_data", exp_a.read_data, rsp_if.read_data);
            compare_field("bus_irq_level", DATA_W'(exp_a.irq_level),
                          DATA_W'(rsp_if.bus_irq_level));
            compare_field("assigned_base", exp_a.assigned_base, rsp_if.assigned_base);
            compare_field("assigned_irq", DATA_W'(exp_a.assigned_irq),
                          DATA_W'(rsp_if.assigned_irq));
            compare_field("status", DATA_W'(exp_a.status), DATA_W'(rsp_if.status));
            compare_field("copy_request", DATA_W'(exp_a.copy_req),
                          DATA_W'(rsp_if.copy_request));
            compare_field("copy_address", exp_a.copy_addr, rsp_if.copy_address);
            compare_field("copy_length", DATA_W'(exp_a.copy_len), DATA_W'(rsp_if.copy_length));
            compare_field("copy_entry", DATA_W'(exp_a.copy_entry), DATA_W'(rsp_if.copy_entry));
         end
      end
   end

   // Long receiver stall while requests keep coming, so the block backs up.
   initial begin
      hold_rsp = 1'b0;
      wait (requests_taken >= 300);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (250) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #400000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int phase;
      int target;
      int pick;
      int steps;
      logic [DATA_W-1:0] value;

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.req_type = '0;
      req_if.reg_offset = '0;
      req_if.write_value = '0;
      req_if.dev_id = '0;
      req_if.dev_base = '0;
      req_if.dev_size = '0;
      req_if.dev_irq = '0;
      req_if.dev_irq_count = '0;
      req_if.name_length = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;

      dev_count = 0;
      reported = '0;
      walk_idx = '0;
      walk_valid = 1'b0;
      free_base = RESET_FREE_BASE;
      free_irq = int'(RESET_FREE_IRQ);
      bus_irq = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, run on the reset values of the free pointers.
      push_access(REQ_READ, OFS_OP, 32'h0);
      push_access(REQ_WRITE, OFS_GET_NAME, 32'h0000_1234);
      push_access(REQ_WRITE, OFS_OP, 32'h0);
      push_access(REQ_WRITE, OFS_OP, 32'hFFFF_FFFF);
      push_access(REQ_READ, OFS_GET_NAME, 32'h0);
      push_access(REQ_READ, 12'hFFF, 32'h0);
      push_access(REQ_WRITE, OFS_NAME_LEN, 32'h5);
      push_access(REQ_UNUSED, OFS_OP, 32'h0);
      push_add(32'h8000_0000, 32'h0, 32'h0000_1000, 5'd0, 6'd2, 8'd0);
      push_add(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 6'd32, 8'd255);
      push_add(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 5'd0, 6'd0, 8'd17);
      push_add(32'h1, 32'h0, 32'h10, 5'd0, 6'd32, 8'd3);
      push_add(32'h2, 32'h0, 32'h10, 5'd0, 6'd28, 8'd9);
      push_add(32'h3, 32'h0, 32'h10, 5'd0, 6'd1, 8'd4);
      push_access(REQ_WRITE, OFS_OP, 32'h0);
      push_access(REQ_READ, OFS_OP, 32'h0);
      push_access(REQ_READ, OFS_OP, 32'h0);
      foreach (FIELD_OFS[k]) push_access(REQ_READ, FIELD_OFS[k], 32'h0);
      push_access(REQ_WRITE, OFS_GET_NAME, 32'hFFFF_FFFF);
      repeat (3) push_access(REQ_READ, OFS_OP, 32'h0);
      settle_block();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_FIRST_FREE_BASE, 32'hFFFF_FFFF);
               write_csr(CSR_FIRST_FREE_IRQ, 32'd31);
            end
            1: begin
               write_csr(CSR_FIRST_FREE_BASE, 32'h0);
               write_csr(CSR_FIRST_FREE_IRQ, 32'd0);
            end
            default: begin
               write_csr(CSR_FIRST_FREE_BASE, $urandom);
               write_csr(CSR_FIRST_FREE_IRQ, $urandom_range(0, 20));
            end
         endcase

         target = queued + PHASE_ITEMS;
         while (queued < target) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
               // A software walk of the table: restart, then step and inspect entries.
               push_access(REQ_WRITE, OFS_OP, 32'h0);
               steps = ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(1, 36);
               repeat (steps) begin
                  push_access(REQ_READ, OFS_OP, $urandom);
                  repeat ($urandom_range(2))
                     push_access(REQ_READ, FIELD_OFS[$urandom_range(5)], $urandom);
                  if ($urandom_range(3) == 0)
                     push_access(REQ_WRITE, OFS_GET_NAME, $urandom);
               end
            end else if (pick < 62) begin
               push_add($urandom,
                        $urandom_range(1) ? 32'h0 :
                           ($urandom_range(9) == 0 ? 32'hFFFF_FFFF : $urandom),
                        ($urandom_range(4) == 0) ? $urandom : $urandom_range(32'h0010_0000),
                        $urandom_range(1) ? 5'd0 : 5'($urandom_range(1, 31)),
                        ($urandom_range(9) < 7) ? 6'($urandom_range(4)) :
                           6'($urandom_range(32)),
                        NAME_W'($urandom_range(255)));
            end else if (pick < 85) begin
               case ($urandom_range(2))
                  0: push_access(REQ_READ, OFS_OP, $urandom);
                  1: push_access(REQ_READ, FIELD_OFS[$urandom_range(5)], $urandom);
                  default: push_access(REQ_WRITE, OFS_GET_NAME, $urandom);
               endcase
            end else begin
               case ($urandom_range(3))
                  0: push_access(REQ_READ, OFS_W'($urandom_range(4095)), $urandom);
                  1: push_access(REQ_WRITE, OFS_W'($urandom_range(4095)), $urandom);
                  2: begin
                     value = $urandom;
                     if (value == '0) value = 32'h1;
                     push_access(REQ_WRITE, OFS_OP, value);
                  end
                  default: push_access(REQ_UNUSED, OFS_W'($urandom_range(4095)), $urandom);
               endcase
            end
         end
         settle_block();
      end

      $display("Run covered %0d requests: %0d devices stored, %0d adds refused %s",
               requests_taken, stored_count, no_irq_count, "for lack of IRQs,");
      $display("%0d adds on a full table, %0d table walks run to the end, %0d name copies, %s",
               full_count, walks_finished, copy_count, "and");
      $display("%0d bad offset or op answers.", bad_count);
      if (error_count == 0 && expected_answers.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
